// ----- rtl/core/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

	// Configuration register indexes
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	localparam int CFG_DATA_W  = 12;
	localparam int SCALE_REG_W = 5;
	localparam int WIDTH_REG_W = 12;

	// Input commands
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic       command;
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic       row_last;
		logic [1:0] pad_bytes;
		logic       source_row_done;
	} out_item_t;

endpackage

// ----- rtl/core/pru_line_store.sv -----
// ----------------------------------------------------------------------------
// pru_line_store
// Single source-row buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pru_line_store
	import pru_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pixel_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pixel_t        rd_data
);

	pixel_t mem [DEPTH];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low, so it can sit in the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/pixel_replicate_upscaler_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler_unit
// Integer nearest-neighbor upscaler for 24-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: a push (command 0) writes one source pixel into the line
//   store; once source_width pixels are in, the row is pending and further
//   pushes are dropped. A pull (command 1) returns the next output pixel;
//   each pixel repeats scale_factor times across, each row scale_factor
//   times down. A pull with no pending row is consumed and gives nothing.
//   out channel: one result per productive pull, in the cycle after the pull
//   transfer, held in the output register until taken.
//   Throughput: one item per cycle; the line store read for a pull is the
//   output register stage. in_stall is high only while a result sits in the
//   output register and out_stall is high.
//   cfg channel: always ready; write only while the block is idle.
//   Reset: scale 1, width 1, no row pending, output empty. The line store
//   content is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_unit
	import pru_pkg::*;
#(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int SCW = $clog2(MAX_SCALE + 1);

	logic [SCALE_REG_W-1:0] scale_q;
	logic [WIDTH_REG_W-1:0] width_q;
	logic [AW-1:0]          fill_col_q;
	logic                   pending_q;
	logic [AW-1:0]          out_col_q;
	logic [RW-1:0]          col_rep_q;
	logic [RW-1:0]          row_rep_q;

	logic                   out_valid_q;
	logic                   row_last_q;
	logic [1:0]             pad_q;
	logic                   src_done_q;

	logic [CW-1:0]          eff_w;
	logic [SCW-1:0]         eff_s;
	logic                   in_xfer;
	logic                   push_ok;
	logic                   pull_ok;
	logic                   fill_last;
	logic                   col_last;
	logic                   row_end;
	logic                   src_done;
	logic [1:0]             pad;
	logic                   out_free;
	pixel_t                 rd_pixel;
	pixel_t                 wr_pixel;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_REG_W'(1);
			width_q <= WIDTH_REG_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[SCALE_REG_W-1:0];
				REG_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as 1, anything above the limit acts as the limit
	always_comb begin
		if (width_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (scale_q == '0) begin
			eff_s = SCW'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			eff_s = SCW'(MAX_SCALE);
		end else begin
			eff_s = SCW'(scale_q);
		end
	end

	// ---------------- item decode ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !out_free;
	assign in_xfer  = in_valid && !in_stall;
	assign push_ok  = in_xfer && (in_data.command == CMD_PUSH) && !pending_q;
	assign pull_ok  = in_xfer && (in_data.command == CMD_PULL) && pending_q;

	assign fill_last = (CW'(fill_col_q) + CW'(1)) >= eff_w;
	assign col_last  = (SCW'(col_rep_q) + SCW'(1)) >= eff_s;
	assign row_end   = col_last && ((CW'(out_col_q) + CW'(1)) >= eff_w);
	assign src_done  = row_end && ((SCW'(row_rep_q) + SCW'(1)) >= eff_s);
	// (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
	assign pad       = row_end ? 2'(2'(eff_w) * 2'(eff_s)) : 2'd0;

	// ---------------- row state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_col_q <= '0;
			pending_q  <= 1'b0;
			out_col_q  <= '0;
			col_rep_q  <= '0;
			row_rep_q  <= '0;
		end else if (push_ok) begin
			if (fill_last) begin
				fill_col_q <= '0;
				pending_q  <= 1'b1;
				out_col_q  <= '0;
				col_rep_q  <= '0;
				row_rep_q  <= '0;
			end else begin
				fill_col_q <= fill_col_q + AW'(1);
			end
		end else if (pull_ok) begin
			if (!col_last) begin
				col_rep_q <= col_rep_q + RW'(1);
			end else begin
				col_rep_q <= '0;
				if (!row_end) begin
					out_col_q <= out_col_q + AW'(1);
				end else begin
					out_col_q <= '0;
					if (src_done) begin
						row_rep_q <= '0;
						pending_q <= 1'b0;
					end else begin
						row_rep_q <= row_rep_q + RW'(1);
					end
				end
			end
		end
	end

	// ---------------- line store ----------------
	assign wr_pixel = '{red: in_data.red_in, green: in_data.green_in, blue: in_data.blue_in};

	pru_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (fill_col_q),
		.wr_data (wr_pixel),
		.rd_en   (pull_ok),
		.rd_addr (out_col_q),
		.rd_data (rd_pixel)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pull_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (pull_ok) begin
			row_last_q <= row_end;
			pad_q      <= pad;
			src_done_q <= src_done;
		end
	end

	assign out_valid                = out_valid_q;
	assign out_data.blue_out        = rd_pixel.blue;
	assign out_data.green_out       = rd_pixel.green;
	assign out_data.red_out         = rd_pixel.red;
	assign out_data.row_last        = row_last_q;
	assign out_data.pad_bytes       = pad_q;
	assign out_data.source_row_done = src_done_q;

	// ---------------- assertions ----------------
	a_done_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && src_done_q |-> row_last_q)
		else $error("source_row_done without row_last");

	a_pad_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (pad_q != 2'd0) |-> row_last_q)
		else $error("pad bytes away from row end");

	a_idle_pull_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_data.command == CMD_PULL) && !pending_q |=> !out_valid_q)
		else $error("result from pull with no pending row");

	a_fill_parked: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (fill_col_q == '0))
		else $error("fill column moved while row pending");

	a_held_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(pad_q) && $stable(row_last_q))
		else $error("held result lost under stall");

endmodule
